// ===== hdl/tcw_pkg.sv =====
// Package for the text console writer: payload structs, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int POS_W      = 11;
  localparam int IN_COL_W   = 7;
  localparam int IN_ROW_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RST      = 8'h07;
  localparam logic              SCROLL_EN_RST = 1'b1;
  localparam logic [CELL_W-1:0] CELL_RST      = 16'h0720;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_ATTR = 1'd0,
    CFG_SCROLL_EN = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    kind_e                kind;
    logic [CHAR_W-1:0]    char_code;
    logic [IN_COL_W-1:0]  col;
    logic [IN_ROW_W-1:0]  row;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_item;
    logic fill;
    logic fill_init;
    logic scr_prime;
    logic scr_step;
    logic home;
    logic finish;
    logic fin_read;
    logic fin_scrolled;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scroll_req;
    logic  cnt_last;
  } status_t;

endpackage

// ===== hdl/text_console_writer.sv =====
// Text console writer top level. Result strobe (done_o) is registered from finish:
// put/move finish in EXEC (one cell write), read in RDWAIT (registered memory read),
// clear and a scrolling put after a sweep of all COLUMNS*ROWS cells, one per cycle.
// Busy stays high until finish, so one transaction at a time; the receiver cannot stall.
// After reset the screen memory is filled with blanks, busy high.
`timescale 1ns / 1ps

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output result_t               result_o
);

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  localparam logic [POS_W-1:0] SCROLL_POS = POS_W'((ROWS - 1) * COLUMNS);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe on consecutive cycles");

  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.scrolled |-> (result_o.cursor_pos == SCROLL_POS)
                                    && (result_o.cell_data == '0))
    else $error("scroll did not leave cursor at start of bottom row");

endmodule

// ===== hdl/tcw_ctrl.sv =====
// Controller FSM of the text console writer: sequences execute, read,
// clear, scroll and the post-reset fill. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RDWAIT = 7'b0001000,
    ST_CLEAR  = 7'b0010000,
    ST_SPRIME = 7'b0100000,
    ST_SCROLL = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill      = 1'b1;
        cmd_o.fill_init = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.kind)
          KIND_PUT: begin
            cmd_o.exec = 1'b1;
            if (status_i.scroll_req) begin
              state_d = ST_SPRIME;
            end else begin
              cmd_o.finish = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          KIND_MOVE: begin
            cmd_o.exec   = 1'b1;
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
          KIND_READ: begin
            cmd_o.rd_item = 1'b1;
            state_d       = ST_RDWAIT;
          end
          default: begin
            state_d = ST_CLEAR;
          end
        endcase
      end
      ST_RDWAIT: begin
        cmd_o.finish   = 1'b1;
        cmd_o.fin_read = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.fill = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.home   = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SPRIME: begin
        cmd_o.scr_prime = 1'b1;
        state_d         = ST_SCROLL;
      end
      ST_SCROLL: begin
        cmd_o.scr_step = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.finish       = 1'b1;
          cmd_o.fin_scrolled = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

// ===== hdl/tcw_datapath.sv =====
// Datapath of the text console writer: screen memory, cursor, config
// registers, sweep counter and result register. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_t                 in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic                  done_o,
  output result_t               result_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (AW > POS_W) ? AW : POS_W;

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

  logic [ATTR_W-1:0] attr_q;
  logic              scroll_en_q;

  kind_e             kind_q;
  logic [CHAR_W-1:0] ch_q;
  logic [CW-1:0]     col_item_q;
  logic [RW-1:0]     row_item_q;

  logic [CW-1:0]     col_cur_q, col_cur_d;
  logic [RW-1:0]     row_cur_q, row_cur_d;
  logic [AW-1:0]     cnt_q;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_q;

  logic              done_q;
  result_t           res_q;

  logic              is_nl, col_last, row_last, wrap;
  logic [CHAR_W-1:0] ch_put;
  logic [CELL_W-1:0] blank;
  logic [AW-1:0]     cur_addr, item_addr;
  logic [AW:0]       step_rd_w;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;
  logic [PW-1:0]     pos_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= ATTR_RST;
      scroll_en_q <= SCROLL_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TEXT_ATTR: attr_q      <= cfg_data_i[ATTR_W-1:0];
        CFG_SCROLL_EN: scroll_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // item latch, coordinates saturated
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= in_i.kind;
      ch_q       <= in_i.char_code;
      col_item_q <= (32'(in_i.col) > COLUMNS - 1) ? LAST_COL : CW'(in_i.col);
      row_item_q <= (32'(in_i.row) > ROWS - 1) ? LAST_ROW : RW'(in_i.row);
    end
  end

  assign is_nl    = (ch_q == CH_NEWLINE);
  assign ch_put   = (ch_q == CH_TAB) ? CH_SPACE : ch_q;
  assign col_last = (col_cur_q == LAST_COL);
  assign row_last = (row_cur_q == LAST_ROW);
  assign wrap     = is_nl || col_last;
  assign blank    = {attr_q, CH_SPACE};

  assign cur_addr  = AW'(row_cur_q) * COLS_A + AW'(col_cur_q);
  assign item_addr = AW'(row_item_q) * COLS_A + AW'(col_item_q);
  assign step_rd_w = (AW + 1)'(cnt_q) + (AW + 1)'(COLUMNS + 1);

  // cursor update
  always_comb begin
    row_cur_d = row_cur_q;
    col_cur_d = col_cur_q;
    if (cmd_i.exec) begin
      case (kind_q)
        KIND_PUT: begin
          if (wrap) begin
            col_cur_d = '0;
            if (!row_last) begin
              row_cur_d = row_cur_q + RW'(1);
            end else if (!scroll_en_q) begin
              row_cur_d = '0;
            end
          end else begin
            col_cur_d = col_cur_q + CW'(1);
          end
        end
        KIND_MOVE: begin
          row_cur_d = row_item_q;
          col_cur_d = col_item_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.home) begin
      row_cur_d = '0;
      col_cur_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cur_q <= '0;
      col_cur_q <= '0;
      cnt_q     <= '0;
    end else begin
      row_cur_q <= row_cur_d;
      col_cur_q <= col_cur_d;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.fill || cmd_i.scr_step) begin
        cnt_q <= cnt_q + AW'(1);
      end
    end
  end

  // memory port selection; scroll reads one row ahead of the write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = {attr_q, ch_put};
    rd_en   = 1'b0;
    rd_addr = item_addr;
    if (cmd_i.exec && (kind_q == KIND_PUT) && !is_nl) begin
      wr_en = 1'b1;
    end
    if (cmd_i.fill) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = cmd_i.fill_init ? CELL_RST : blank;
    end
    if (cmd_i.scr_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = (cnt_q < COPY_END) ? rd_q : blank;
      rd_en   = (step_rd_w < (AW + 1)'(CELLS));
      rd_addr = step_rd_w[AW-1:0];
    end
    if (cmd_i.scr_prime) begin
      rd_en   = 1'b1;
      rd_addr = COLS_A;
    end
    if (cmd_i.rd_item) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // result register
  assign pos_d = PW'(row_cur_d) * PW'(COLUMNS) + PW'(col_cur_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.cursor_pos <= pos_d[POS_W-1:0];
      res_q.cell_data  <= cmd_i.fin_read ? rd_q : '0;
      res_q.scrolled   <= cmd_i.fin_scrolled;
    end
  end

  assign status_o.kind       = kind_q;
  assign status_o.scroll_req = (kind_q == KIND_PUT) && wrap && row_last && scroll_en_q;
  assign status_o.cnt_last   = (cnt_q == LAST_CELL);

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== tb/text_console_writer_test.sv =====
// Self-checking testbench for text_console_writer: drives put, move, read and clear
// transactions, predicts the screen, cursor and scroll flag, and checks every result.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int NCOL     = COLUMNS_DEF;
  localparam int NROW     = ROWS_DEF;
  localparam int NCELL    = NCOL * NROW;
  localparam int STALL_MAX = 20000;
  localparam int RAND_ITEMS = 1950;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  item_t                 in_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  result_t               result_o;

  text_console_writer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  // screen predictor state
  logic [CELL_W-1:0] screen_model [NCELL];
  int unsigned       crs_row;
  int unsigned       crs_col;
  logic [ATTR_W-1:0] attr_reg;
  logic              scroll_reg;

  result_t cursor_reports_q [$];
  int      fails;
  int      item_count;
  int      stall_cycles;
  bit      gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_reg, CH_SPACE};
  endfunction

  function automatic bit advance_row();
    crs_col = 0;
    crs_row++;
    if (crs_row < NROW) return 1'b0;
    if (!scroll_reg) begin
      crs_row = 0;
      return 1'b0;
    end
    for (int i = 0; i < NCELL - NCOL; i++) screen_model[i] = screen_model[i + NCOL];
    for (int i = NCELL - NCOL; i < NCELL; i++) screen_model[i] = blank_cell();
    crs_row = NROW - 1;
    return 1'b1;
  endfunction

  function automatic result_t console_apply(item_t it);
    result_t           res;
    int unsigned       c;
    int unsigned       r;
    logic [CHAR_W-1:0] ch;
    c = (it.col > NCOL - 1) ? NCOL - 1 : it.col;
    r = (it.row > NROW - 1) ? NROW - 1 : it.row;
    ch = it.char_code;
    res = '0;
    case (it.kind)
      KIND_PUT: begin
        if (ch == CH_NEWLINE) begin
          res.scrolled = advance_row();
        end else begin
          if (ch == CH_TAB) ch = CH_SPACE;
          screen_model[crs_row * NCOL + crs_col] = {attr_reg, ch};
          crs_col++;
          if (crs_col >= NCOL) res.scrolled = advance_row();
        end
      end
      KIND_MOVE: begin
        crs_row = r;
        crs_col = c;
      end
      KIND_READ: begin
        res.cell_data = screen_model[r * NCOL + c];
      end
      default: begin
        for (int i = 0; i < NCELL; i++) screen_model[i] = blank_cell();
        crs_row = 0;
        crs_col = 0;
      end
    endcase
    res.cursor_pos = POS_W'(crs_row * NCOL + crs_col);
    return res;
  endfunction

  function automatic item_t make_item(kind_e k, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
    item_t it;
    it.kind      = k;
    it.char_code = ch;
    it.col       = c;
    it.row       = r;
    return it;
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic send_item(item_t it);
    if (gaps_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cursor_reports_q.push_back(console_apply(it));
    item_count++;
    @(negedge clk_i);
  endtask

  task automatic put_char(logic [7:0] ch);
    send_item(make_item(KIND_PUT, ch, 7'($urandom), 5'($urandom)));
  endtask

  task automatic move_to(logic [6:0] c, logic [4:0] r);
    send_item(make_item(KIND_MOVE, 8'($urandom), c, r));
  endtask

  task automatic read_at(logic [6:0] c, logic [4:0] r);
    send_item(make_item(KIND_READ, 8'($urandom), c, r));
  endtask

  task automatic clear_screen();
    send_item(make_item(KIND_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom)));
  endtask

  // wait until every transaction has reported and the block is quiet
  task automatic settle();
    start <= 1'b0;
    while (cursor_reports_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic configure(logic [ATTR_W-1:0] attr, logic scroll_en);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TEXT_ATTR;
    cfg_data_i <= attr;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_SCROLL_EN;
    cfg_data_i <= CFG_DATA_W'(scroll_en);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    attr_reg   = attr;
    scroll_reg = scroll_en;
    @(negedge clk_i);
  endtask

  task automatic test_reset_state();
    read_at(7'd0, 5'd0);
    read_at(7'd127, 5'd31);
  endtask

  task automatic test_put_chars();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CH_TAB);
    put_char(CH_NEWLINE);
    put_char(8'h41);
    read_at(7'd0, 5'd0);
    read_at(7'd1, 5'd0);
    read_at(7'd2, 5'd0);
    read_at(7'd0, 5'd1);
  endtask

  task automatic test_cursor_moves();
    move_to(7'd127, 5'd31);
    move_to(7'd79, 5'd0);
    move_to(7'd0, 5'd24);
  endtask

  task automatic test_bottom_scroll();
    move_to(7'd78, 5'd24);
    put_char(8'h78);
    put_char(8'h79);
    read_at(7'd79, 5'd23);
    read_at(7'd0, 5'd24);
    put_char(CH_NEWLINE);
  endtask

  task automatic test_clear();
    clear_screen();
  endtask

  task automatic test_wrap_without_scroll();
    settle();
    configure(8'hFF, 1'b0);
    move_to(7'd79, 5'd24);
    put_char(8'h7A);
    move_to(7'd5, 5'd24);
    put_char(CH_NEWLINE);
    read_at(7'd79, 5'd24);
  endtask

  task automatic random_text_run();
    int         len;
    int         pick;
    logic [7:0] ch;
    len = $urandom_range(1, 100);
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 8) ch = CH_NEWLINE;
      else if (pick < 13) ch = CH_TAB;
      else ch = 8'($urandom);
      put_char(ch);
    end
  endtask

  task automatic random_burst();
    int         pick;
    logic [6:0] c;
    logic [4:0] r;
    pick = $urandom_range(99);
    if (pick < 55) begin
      random_text_run();
    end else if (pick < 75) begin
      c = ($urandom_range(9) < 8) ? 7'($urandom_range(0, NCOL - 1)) : 7'($urandom);
      r = ($urandom_range(9) < 8) ? 5'($urandom_range(0, NROW - 1)) : 5'($urandom);
      move_to(c, r);
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 6)) begin
        c = 7'($urandom);
        if ($urandom_range(1)) r = 5'(crs_row);
        else r = 5'($urandom);
        read_at(c, r);
      end
    end else begin
      clear_screen();
    end
  endtask

  task automatic test_random();
    int phase_end;
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: configure(8'($urandom), 1'b1);
        1: configure(8'h00, 1'b0);
        2: configure(8'hFF, 1'b1);
        default: configure(8'($urandom), 1'($urandom));
      endcase
      gaps_on = (p != 1);
      phase_end = item_count + RAND_ITEMS / 4;
      while (item_count < phase_end) random_burst();
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && done_o) begin
      if (cursor_reports_q.size() == 0) begin
        $error("unexpected result: cursor_pos %0d", result_o.cursor_pos);
        fails++;
      end else begin
        exp_res = cursor_reports_q.pop_front();
        if (result_o.cursor_pos !== exp_res.cursor_pos) begin
          $error("cursor_pos: expected %0d, got %0d", exp_res.cursor_pos, result_o.cursor_pos);
          fails++;
        end
        if (result_o.cell_data !== exp_res.cell_data) begin
          $error("cell_data: expected %h, got %h", exp_res.cell_data, result_o.cell_data);
          fails++;
        end
        if (result_o.scrolled !== exp_res.scrolled) begin
          $error("scrolled: expected %0d, got %0d", exp_res.scrolled, result_o.scrolled);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("text_console_writer regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    start        = 1'b0;
    in_i         = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_TEXT_ATTR;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    fails        = 0;
    item_count   = 0;
    stall_cycles = 0;
    gaps_on      = 1'b1;
    attr_reg     = ATTR_RST;
    scroll_reg   = SCROLL_EN_RST;
    crs_row      = 0;
    crs_col      = 0;
    for (int i = 0; i < NCELL; i++) screen_model[i] = CELL_RST;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_put_chars();
    test_cursor_moves();
    test_bottom_scroll();
    test_clear();
    test_wrap_without_scroll();
    test_random();

    start <= 1'b0;
    while (cursor_reports_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fails == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule
